### rtl/core/gripper_move_completion_monitor_defines.svh
// ----------------------------------------------------------------------------
// gripper move completion monitor assertion macros
// shared property wrappers, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef GRIPPER_MOVE_COMPLETION_MONITOR_DEFINES_SVH
`define GRIPPER_MOVE_COMPLETION_MONITOR_DEFINES_SVH

// same-cycle implication
`define GMCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gmcm_pkg.sv
// ----------------------------------------------------------------------------
// gmcm_pkg
// types and constants of the gripper move completion monitor
// ----------------------------------------------------------------------------
package gmcm_pkg;

  localparam int unsigned PosBits  = 8;
  localparam int unsigned CfgBits  = 8;
  localparam int unsigned RepBits  = 8;
  localparam int unsigned AddrBits = 4;
  localparam int unsigned DataBits = 32;

  localparam logic [PosBits-1:0] ClosingLimit   = PosBits'(1) << (PosBits - 1);
  localparam logic [PosBits-1:0] NearOpenTarget = PosBits'(200);
  localparam logic [RepBits-1:0] RepeatMax      = {RepBits{1'b1}};

  localparam logic [CfgBits-1:0] PosTolRst     = CfgBits'(5);
  localparam logic [CfgBits-1:0] OpenThrRst    = CfgBits'(200);
  localparam logic [CfgBits-1:0] StableLimRst  = CfgBits'(10);
  localparam logic [CfgBits-1:0] OpenMinProgRst = CfgBits'(150);

  typedef enum logic [1:0] {
    OpStart    = 2'd0,
    OpFeedback = 2'd1,
    OpTimeout  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StMoving  = 2'd0,
    StArrived = 2'd1,
    StStalled = 2'd2,
    StDropped = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OutPending = 3'd0,
    OutSuccess = 3'd1,
    OutGrasped = 3'd2,
    OutDropped = 3'd3,
    OutTimeout = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    RegPosTol      = 2'd0,
    RegOpenThr     = 2'd1,
    RegStableLim   = 2'd2,
    RegOpenMinProg = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PosBits-1:0] target_pos;
    logic [1:0]         status_code;
    logic [PosBits-1:0] feedback_pos;
  } in_item_t;

  typedef struct packed {
    logic       done_res;
    logic [2:0] outcome;
  } out_item_t;

  typedef struct packed {
    logic [CfgBits-1:0] pos_tolerance;
    logic [CfgBits-1:0] open_threshold;
    logic [CfgBits-1:0] stable_limit;
    logic [CfgBits-1:0] open_min_progress;
  } cfg_t;

  typedef struct packed {
    logic               active;
    logic [PosBits-1:0] target;
    logic               closing;
    logic               fb_seen;
    logic [PosBits-1:0] max_position;
    logic [PosBits-1:0] last_position;
    logic [RepBits-1:0] repeat_count;
  } trk_t;

endpackage

### rtl/core/gmcm_cfg_regs.sv
// ----------------------------------------------------------------------------
// gmcm_cfg_regs
// apb register file holding tolerance, thresholds and limits
// ----------------------------------------------------------------------------
module gmcm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmcm_pkg::AddrBits-1:0] paddr,
  input  logic [gmcm_pkg::DataBits-1:0] pwdata,
  output logic [gmcm_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output gmcm_pkg::cfg_t                cfg_o
);
  import gmcm_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegPosTol:      cfg_d.pos_tolerance     = pwdata[CfgBits-1:0];
        RegOpenThr:     cfg_d.open_threshold    = pwdata[CfgBits-1:0];
        RegStableLim:   cfg_d.stable_limit      = pwdata[CfgBits-1:0];
        RegOpenMinProg: cfg_d.open_min_progress = pwdata[CfgBits-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_tolerance     <= PosTolRst;
      cfg_q.open_threshold    <= OpenThrRst;
      cfg_q.stable_limit      <= StableLimRst;
      cfg_q.open_min_progress <= OpenMinProgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      RegPosTol:      prdata = DataBits'(cfg_q.pos_tolerance);
      RegOpenThr:     prdata = DataBits'(cfg_q.open_threshold);
      RegStableLim:   prdata = DataBits'(cfg_q.stable_limit);
      RegOpenMinProg: prdata = DataBits'(cfg_q.open_min_progress);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/gmcm_judge.sv
// ----------------------------------------------------------------------------
// gmcm_judge
// decides the outcome of one item and the tracking state it leaves behind
// ----------------------------------------------------------------------------
module gmcm_judge (
  input  gmcm_pkg::in_item_t  item_i,
  input  gmcm_pkg::cfg_t      cfg_i,
  input  gmcm_pkg::trk_t      trk_i,
  output gmcm_pkg::trk_t      trk_o,
  output gmcm_pkg::out_item_t res_o
);
  import gmcm_pkg::*;

  op_e                op;
  status_e            st;
  logic [PosBits-1:0] p;
  logic [PosBits-1:0] diff;
  logic               near;
  logic               at_open;
  logic               repeated;
  logic [RepBits-1:0] rep_next;
  outcome_e           fb_out;
  outcome_e           res_out;

  assign op = op_e'(item_i.operation);
  assign st = status_e'(item_i.status_code);
  assign p  = item_i.feedback_pos;

  assign diff    = (p >= trk_i.target) ? (p - trk_i.target) : (trk_i.target - p);
  assign near    = {{CfgBits{1'b0}}, diff} <= {{PosBits{1'b0}}, cfg_i.pos_tolerance};
  assign at_open = {{CfgBits{1'b0}}, p} >= {{PosBits{1'b0}}, cfg_i.open_threshold};

  assign repeated = trk_i.fb_seen && (p == trk_i.last_position);
  assign rep_next = !repeated ? '0 :
                    (trk_i.repeat_count == RepeatMax) ? RepeatMax :
                    trk_i.repeat_count + RepBits'(1);

  always_comb begin
    fb_out = OutPending;
    priority if (st == StDropped) begin
      fb_out = OutDropped;
    end else if (st == StArrived && (near || (!trk_i.closing &&
                 trk_i.target >= NearOpenTarget && at_open))) begin
      fb_out = OutSuccess;
    end else if (st == StStalled && trk_i.closing) begin
      fb_out = OutGrasped;
    end else if (st == StStalled && at_open) begin
      fb_out = OutSuccess;
    end else if (near) begin
      fb_out = OutSuccess;
    end else if (rep_next >= cfg_i.stable_limit) begin
      fb_out = OutSuccess;
    end
  end

  always_comb begin
    trk_o   = trk_i;
    res_out = OutPending;
    res_o   = '0;
    unique case (op)
      OpStart: begin
        trk_o.active        = 1'b1;
        trk_o.target        = item_i.target_pos;
        trk_o.closing       = item_i.target_pos < ClosingLimit;
        trk_o.fb_seen       = 1'b0;
        trk_o.max_position  = '0;
        trk_o.last_position = '0;
        trk_o.repeat_count  = '0;
      end
      OpFeedback: begin
        if (trk_i.active) begin
          if (!trk_i.fb_seen || p > trk_i.max_position) begin
            trk_o.max_position = p;
          end
          trk_o.last_position = p;
          trk_o.repeat_count  = rep_next;
          trk_o.fb_seen       = 1'b1;
          res_out             = fb_out;
          res_o.done_res      = fb_out != OutPending;
          trk_o.active        = fb_out == OutPending;
        end
      end
      OpTimeout: begin
        if (trk_i.active) begin
          res_out = (!trk_i.closing && trk_i.fb_seen &&
                     {{CfgBits{1'b0}}, trk_i.max_position} >=
                     {{PosBits{1'b0}}, cfg_i.open_min_progress}) ? OutSuccess : OutTimeout;
          res_o.done_res = 1'b1;
          trk_o.active   = 1'b0;
        end
      end
      default: res_out = OutPending;
    endcase
    res_o.outcome = res_out;
  end

endmodule

### rtl/core/gripper_move_completion_monitor.sv
// ----------------------------------------------------------------------------
// gripper_move_completion_monitor
// tracks gripper feedback for a move and reports when and how it finished
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_item_i  (gmcm_pkg::in_item_t)
//  out     | output    | out_valid_o/out_ready_i| out_item_o (gmcm_pkg::out_item_t)
//  cfg     | input     | apb psel/penable/pready| paddr/pwdata/prdata
//
//  one beat per cycle in both directions while out_ready_i is high; a result is
//  offered once its input beat has passed the input register, then the result register
//  reset clears the move state and loads the register defaults
//  a stalled output holds the result while the input register still takes a
//  beat; in_ready_o falls only when both registers are full and out_ready_i is low
// ----------------------------------------------------------------------------
`include "gripper_move_completion_monitor_defines.svh"

module gripper_move_completion_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gmcm_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gmcm_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmcm_pkg::AddrBits-1:0] paddr,
  input  logic [gmcm_pkg::DataBits-1:0] pwdata,
  output logic [gmcm_pkg::DataBits-1:0] prdata,
  output logic                          pready
);
  import gmcm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  out_item_t res;
  logic      out_vld_q;
  trk_t      trk_q;
  trk_t      trk_d;
  logic      advance;
  logic      proc_fire;

  gmcm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gmcm_judge u_judge (
    .item_i (in_q),
    .cfg_i  (cfg),
    .trk_i  (trk_q),
    .trk_o  (trk_d),
    .res_o  (res)
  );

  assign advance    = !out_vld_q || out_ready_i;
  assign proc_fire  = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // move state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (proc_fire) begin
        trk_q <= trk_d;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  `GMCM_ASSERT_IMP(a_done_matches_outcome, out_vld_q, (out_q.done_res == (out_q.outcome != OutPending)), "done flag disagrees with outcome")
  `GMCM_ASSERT_NXT(a_done_ends_move, proc_fire && res.done_res, !trk_q.active, "move still active after finishing beat")
  `GMCM_ASSERT_NXT(a_start_opens_move, proc_fire && (in_q.operation == OpStart), trk_q.active && !trk_q.fb_seen, "start beat did not open a fresh move")

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gripper move completion monitor: a queue-fed
// driver offers input beats, a clocked monitor compares every result against
// an in-bench predictor of the move tracking and verdict rules, over several
// register settings and handshake idling patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gmcm_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RxHoldCycles = 80;
  localparam int unsigned PhaseBeats   = 50;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [1:0]  OpUnused     = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0] pwdata      = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  in_item_t    pending_beats [$];
  out_item_t   expected_results [$];
  cfg_t        limits;
  trk_t        track;
  int unsigned queued_beats   = 0;
  int unsigned beats_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned outcome_tally [8];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold_req    = 1'b0;
  int unsigned rx_hold_cnt    = 0;

  gripper_move_completion_monitor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic out_item_t judge_beat(in_item_t beat);
    out_item_t          res;
    logic [PosBits-1:0] p;
    logic [PosBits-1:0] gap;
    logic               near;
    logic [2:0]         verdict;
    res = '0;
    res.outcome = OutPending;
    if (beat.operation == OpStart) begin
      track.active        = 1'b1;
      track.target        = beat.target_pos;
      track.closing       = beat.target_pos < ClosingLimit;
      track.fb_seen       = 1'b0;
      track.max_position  = '0;
      track.last_position = '0;
      track.repeat_count  = '0;
    end else if (beat.operation == OpFeedback && track.active) begin
      p = beat.feedback_pos;
      if (!track.fb_seen || p > track.max_position) track.max_position = p;
      if (track.fb_seen && p == track.last_position) begin
        if (track.repeat_count != RepeatMax) track.repeat_count = track.repeat_count + 8'd1;
      end else begin
        track.repeat_count  = '0;
        track.last_position = p;
      end
      track.fb_seen = 1'b1;
      gap = (p >= track.target) ? p - track.target : track.target - p;
      near = gap <= limits.pos_tolerance;
      verdict = OutPending;
      if (beat.status_code == StDropped) begin
        verdict = OutDropped;
      end else if (beat.status_code == StArrived && (near || (!track.closing &&
                   track.target >= NearOpenTarget && p >= limits.open_threshold))) begin
        verdict = OutSuccess;
      end else if (beat.status_code == StStalled && track.closing) begin
        verdict = OutGrasped;
      end else if (beat.status_code == StStalled && p >= limits.open_threshold) begin
        verdict = OutSuccess;
      end else if (near || track.repeat_count >= limits.stable_limit) begin
        verdict = OutSuccess;
      end
      if (verdict != OutPending) begin
        res.done_res = 1'b1;
        track.active = 1'b0;
      end
      res.outcome = verdict;
    end else if (beat.operation == OpTimeout && track.active) begin
      if (!track.closing && track.fb_seen &&
          track.max_position >= limits.open_min_progress) begin
        res.outcome = OutSuccess;
      end else begin
        res.outcome = OutTimeout;
      end
      res.done_res = 1'b1;
      track.active = 1'b0;
    end
    return res;
  endfunction

  task automatic add_beat(input logic [1:0] op, input logic [PosBits-1:0] tgt,
                          input logic [1:0] st, input logic [PosBits-1:0] pos);
    pending_beats.push_back({op, tgt, st, pos});
    queued_beats++;
  endtask

  function automatic logic [1:0] drift_status();
    if ($urandom_range(0, 99) < 85) return StMoving;
    return 2'($urandom_range(1, 3));
  endfunction

  // a start, travel, a run of equal positions, maybe an ending; or one stray beat
  task automatic add_move();
    logic [PosBits-1:0] tgt;
    logic [PosBits-1:0] stop;
    int unsigned        reps;
    if ($urandom_range(0, 9) == 0) begin
      add_beat(2'($urandom_range(1, 3)), PosBits'($urandom), 2'($urandom),
               PosBits'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: tgt = PosBits'($urandom_range(0, 127));
        1: tgt = PosBits'($urandom_range(200, 255));
        2: tgt = PosBits'($urandom_range(128, 199));
        default: tgt = PosBits'($urandom);
      endcase
      add_beat(OpStart, tgt, 2'($urandom), PosBits'($urandom));
      repeat ($urandom_range(0, 5)) begin
        add_beat(OpFeedback, PosBits'($urandom), drift_status(), PosBits'($urandom));
      end
      stop = PosBits'($urandom);
      reps = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
      repeat (reps) add_beat(OpFeedback, PosBits'($urandom), StMoving, stop);
      case ($urandom_range(0, 5))
        0: add_beat(OpTimeout, PosBits'($urandom), 2'($urandom), PosBits'($urandom));
        1: add_beat(OpFeedback, PosBits'($urandom), StArrived,
                    tgt + PosBits'($urandom_range(0, 8)) - PosBits'(4));
        2: add_beat(OpFeedback, PosBits'($urandom), StStalled, PosBits'($urandom));
        3: add_beat(OpFeedback, PosBits'($urandom), StDropped, PosBits'($urandom));
        4: add_beat(OpFeedback, PosBits'($urandom), StArrived, PosBits'($urandom));
        default: ;
      endcase
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgBits-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataBits'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPosTol:      limits.pos_tolerance     = val;
      RegOpenThr:     limits.open_threshold    = val;
      RegStableLim:   limits.stable_limit      = val;
      RegOpenMinProg: limits.open_min_progress = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive
    logic     nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid_i;
    nxt_item  = in_item_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(judge_beat(in_item_i));
        beats_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_beats.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_item  = pending_beats.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
    in_item_i  <= nxt_item;
  end

  always @(posedge clk_i) begin : hold_count
    if (!rx_hold_req) begin
      rx_hold_cnt <= 0;
    end else if (rx_hold_cnt != RxHoldCycles) begin
      rx_hold_cnt <= rx_hold_cnt + 1;
    end
  end

  always @(posedge clk_i) begin : check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        if (fail_count < ReportLimit) begin
          $display("unexpected result beat: done %0b outcome %0d",
                   out_item_o.done_res, out_item_o.outcome);
        end
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.done_res !== want.done_res || out_item_o.outcome !== want.outcome) begin
          if (fail_count < ReportLimit) begin
            $display("result %0d mismatch: expected done %0b outcome %0d, got done %0b outcome %0d",
                     results_seen, want.done_res, want.outcome,
                     out_item_o.done_res, out_item_o.outcome);
          end
          fail_count++;
        end
        if (want.done_res) outcome_tally[want.outcome]++;
      end
    end
    out_ready_i <= rst_ni && !(rx_hold_req && rx_hold_cnt != RxHoldCycles) &&
                   $urandom_range(0, 99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("gripper_move_completion_monitor verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t        plan [6];
    cfg_t        setting;
    int unsigned goal;
    plan[0] = {8'd5, 8'd200, 8'd10, 8'd150};
    plan[1] = {8'd0, 8'd255, 8'd1, 8'd255};
    plan[2] = {8'd255, 8'd0, 8'd255, 8'd0};
    plan[3] = '0;
    plan[4] = {8'd3, 8'd128, 8'd0, 8'd200};
    plan[5] = {8'd12, 8'd180, 8'd4, 8'd100};
    limits = {PosTolRst, OpenThrRst, StableLimRst, OpenMinProgRst};
    track  = '0;
    foreach (outcome_tally[k]) outcome_tally[k] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct  <= 8;
    recv_stall_pct <= 54;

    // no move running, unused code, then every kind of ending, some more than once
    add_beat(OpFeedback, 8'hFF, StDropped, 8'hFF);
    add_beat(OpTimeout, 8'hFF, StStalled, 8'h00);
    add_beat(OpUnused, 8'hFF, 2'b11, 8'hFF);
    add_beat(OpStart, 8'h00, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StMoving, 8'h00);
    add_beat(OpStart, 8'hFF, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StArrived, 8'd210);
    add_beat(OpStart, 8'd127, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StStalled, 8'd50);
    add_beat(OpStart, 8'd128, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StStalled, 8'd201);
    add_beat(OpStart, 8'd128, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StMoving, 8'd20);
    add_beat(OpUnused, 8'h00, StMoving, 8'd20);
    add_beat(OpStart, 8'd60, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StDropped, 8'hFF);
    add_beat(OpStart, 8'd100, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StMoving, 8'd30);
    add_beat(OpTimeout, 8'h00, StMoving, 8'h00);
    add_beat(OpStart, 8'd220, StMoving, 8'h00);
    add_beat(OpFeedback, 8'h00, StMoving, 8'd160);
    add_beat(OpTimeout, 8'h00, StMoving, 8'h00);
    add_beat(OpStart, 8'd220, StMoving, 8'h00);
    add_beat(OpTimeout, 8'h00, StMoving, 8'h00);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      setting = (phase == 3) ? cfg_t'($urandom) : plan[phase];
      write_reg(RegPosTol, setting.pos_tolerance);
      write_reg(RegOpenThr, setting.open_threshold);
      write_reg(RegStableLim, setting.stable_limit);
      write_reg(RegOpenMinProg, setting.open_min_progress);
      send_idle_pct  <= (phase < 2) ? 8 : (phase < 4) ? 54 : 0;
      recv_stall_pct <= (phase < 2) ? 54 : (phase < 4) ? 8 : 0;
      // long output hold-off while beats keep coming
      rx_hold_req    <= (phase == 4);
      for (int half = 0; half < 2; half++) begin
        goal = queued_beats + PhaseBeats / 2;
        while (queued_beats < goal) add_move();
        if (phase == 3 && half == 0) wait_drained();
      end
      wait_drained();
    end

    $display("ran %0d input beats over six register settings and three idling patterns, %0d results",
             beats_accepted, results_seen);
    $display("moves ended: success %0d, grasped %0d, dropped %0d, timeout %0d",
             outcome_tally[OutSuccess], outcome_tally[OutGrasped],
             outcome_tally[OutDropped], outcome_tally[OutTimeout]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("gripper_move_completion_monitor verification clean");
    end else begin
      $display("gripper_move_completion_monitor verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gmcm_pkg.sv
rtl/core/gmcm_cfg_regs.sv
rtl/core/gmcm_judge.sv
rtl/core/gripper_move_completion_monitor.sv
sim/tb_top.sv
